[rtl/cyrtl_pkg.sv]
// Package for the Cyrillic to Latin transliterator: shared types, byte codes
// and the Latin spelling table. Depends on nothing; used by every RTL file.
`default_nettype none

package cyrtl_pkg;

   // UTF-8 byte codes.
   localparam logic [2:0] LEAD_TOP     = 3'b110;   // top bits of a two-byte lead
   localparam logic [7:0] LEAD_D0      = 8'hD0;
   localparam logic [7:0] LEAD_D1      = 8'hD1;
   localparam logic [7:0] YO_LOWER_LO  = 8'h91;    // second byte of lower case yo
   localparam logic [7:0] YO_UPPER_LO  = 8'h81;    // second byte of upper case yo
   localparam logic [7:0] CASE_OFFSET  = 8'h20;
   localparam logic [7:0] ASCII_LC_A   = 8'h61;
   localparam logic [7:0] ASCII_LC_Z   = 8'h7A;

   // Latin spelling of one letter: 1 to 3 characters, first in the low byte.
   typedef struct packed {
      logic [1:0]      len;
      logic [2:0][7:0] chars;
   } cyrtl_latin_type;

   // What one input word produces: up to three result words and the new
   // held-lead state.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            hold;
      logic [7:0]      held;
   } cyrtl_xlat_type;

   // Lower case letters a..ya without yo, in code order.
   function automatic cyrtl_latin_type latin_lookup(input logic [4:0] idx);
      cyrtl_latin_type res;
      res.len   = 2'd1;
      res.chars = '0;
      case (idx)
         5'd0:  res.chars = {8'h00, 8'h00, 8'h61};          // a
         5'd1:  res.chars = {8'h00, 8'h00, 8'h62};          // b
         5'd2:  res.chars = {8'h00, 8'h00, 8'h76};          // v
         5'd3:  res.chars = {8'h00, 8'h00, 8'h67};          // g
         5'd4:  res.chars = {8'h00, 8'h00, 8'h64};          // d
         5'd5:  res.chars = {8'h00, 8'h00, 8'h65};          // e
         5'd6:  begin res.len = 2'd2; res.chars = {8'h00, 8'h68, 8'h7A}; end  // zh
         5'd7:  res.chars = {8'h00, 8'h00, 8'h7A};          // z
         5'd8:  res.chars = {8'h00, 8'h00, 8'h69};          // i
         5'd9:  res.chars = {8'h00, 8'h00, 8'h79};          // short i
         5'd10: res.chars = {8'h00, 8'h00, 8'h6B};          // k
         5'd11: res.chars = {8'h00, 8'h00, 8'h6C};          // l
         5'd12: res.chars = {8'h00, 8'h00, 8'h6D};          // m
         5'd13: res.chars = {8'h00, 8'h00, 8'h6E};          // n
         5'd14: res.chars = {8'h00, 8'h00, 8'h6F};          // o
         5'd15: res.chars = {8'h00, 8'h00, 8'h70};          // p
         5'd16: res.chars = {8'h00, 8'h00, 8'h72};          // r
         5'd17: res.chars = {8'h00, 8'h00, 8'h73};          // s
         5'd18: res.chars = {8'h00, 8'h00, 8'h74};          // t
         5'd19: res.chars = {8'h00, 8'h00, 8'h75};          // u
         5'd20: res.chars = {8'h00, 8'h00, 8'h66};          // f
         5'd21: begin res.len = 2'd2; res.chars = {8'h00, 8'h68, 8'h6B}; end  // kh
         5'd22: begin res.len = 2'd2; res.chars = {8'h00, 8'h73, 8'h74}; end  // ts
         5'd23: begin res.len = 2'd2; res.chars = {8'h00, 8'h68, 8'h63}; end  // ch
         5'd24: begin res.len = 2'd2; res.chars = {8'h00, 8'h68, 8'h73}; end  // sh
         5'd25: begin res.len = 2'd3; res.chars = {8'h68, 8'h63, 8'h73}; end  // sch
         5'd26: res.chars = {8'h00, 8'h00, 8'h22};          // hard sign
         5'd27: res.chars = {8'h00, 8'h00, 8'h79};          // y
         5'd28: res.chars = {8'h00, 8'h00, 8'h27};          // soft sign
         5'd29: res.chars = {8'h00, 8'h00, 8'h65};          // e
         5'd30: begin res.len = 2'd2; res.chars = {8'h00, 8'h75, 8'h79}; end  // yu
         5'd31: begin res.len = 2'd2; res.chars = {8'h00, 8'h61, 8'h79}; end  // ya
         default: res.chars = '0;
      endcase
      return res;
   endfunction

   localparam cyrtl_latin_type LATIN_YO = '{len: 2'd2, chars: {8'h00, 8'h6F, 8'h79}};

endpackage

`default_nettype wire

[rtl/cyrtl_xlat.sv]
// Combinational translation of one input word against the held lead byte.
// Depends on cyrtl_pkg for the spelling table and the result type.
`default_nettype none

module cyrtl_xlat (
   input  wire logic                     in_flush,
   input  wire logic [7:0]               in_byte,
   input  wire logic                     pending,
   input  wire logic [7:0]               held,
   output cyrtl_pkg::cyrtl_xlat_type     xlat
);

   cyrtl_pkg::cyrtl_latin_type spell;
   logic                       is_letter;
   logic                       upper;
   logic [7:0]                 first_char;

   // Decode the lead/second pair into a letter, if it is one.
   always_comb begin
      is_letter = 1'b1;
      upper     = 1'b0;
      spell     = cyrtl_pkg::LATIN_YO;
      if (held == cyrtl_pkg::LEAD_D0 && in_byte inside {[8'hB0:8'hBF]}) begin
         spell = cyrtl_pkg::latin_lookup({1'b0, in_byte[3:0]});
      end else if (held == cyrtl_pkg::LEAD_D1 && in_byte inside {[8'h80:8'h8F]}) begin
         spell = cyrtl_pkg::latin_lookup({1'b1, in_byte[3:0]});
      end else if (held == cyrtl_pkg::LEAD_D1 && in_byte == cyrtl_pkg::YO_LOWER_LO) begin
         spell = cyrtl_pkg::LATIN_YO;
      end else if (held == cyrtl_pkg::LEAD_D0 && in_byte inside {[8'h90:8'hAF]}) begin
         // 0x90..0x9F map to a..p, 0xA0..0xAF to r..ya.
         spell = cyrtl_pkg::latin_lookup({in_byte[5], in_byte[3:0]});
         upper = 1'b1;
      end else if (held == cyrtl_pkg::LEAD_D0 && in_byte == cyrtl_pkg::YO_UPPER_LO) begin
         spell = cyrtl_pkg::LATIN_YO;
         upper = 1'b1;
      end else begin
         is_letter = 1'b0;
      end
   end

   // Capitalize only a letter; the hard and soft signs keep their marks.
   always_comb begin
      first_char = spell.chars[0];
      if (upper && (spell.chars[0] inside {[cyrtl_pkg::ASCII_LC_A:cyrtl_pkg::ASCII_LC_Z]})) begin
         first_char = spell.chars[0] - cyrtl_pkg::CASE_OFFSET;
      end
   end

   always_comb begin
      xlat.count = 2'd0;
      xlat.bytes = '0;
      xlat.hold  = pending;
      xlat.held  = held;
      if (in_flush) begin
         if (pending) begin
            xlat.count    = 2'd1;
            xlat.bytes[0] = held;
            xlat.hold     = 1'b0;
            xlat.held     = 8'h00;
         end
      end else if (pending) begin
         xlat.hold = 1'b0;
         xlat.held = 8'h00;
         if (is_letter) begin
            xlat.count = spell.len;
            xlat.bytes = {spell.chars[2], spell.chars[1], first_char};
         end else begin
            xlat.count    = 2'd2;
            xlat.bytes[0] = held;
            xlat.bytes[1] = in_byte;
         end
      end else if (in_byte[7:5] == cyrtl_pkg::LEAD_TOP) begin
         xlat.hold = 1'b1;
         xlat.held = in_byte;
      end else begin
         xlat.count    = 2'd1;
         xlat.bytes[0] = in_byte;
      end
   end

endmodule

`default_nettype wire

[rtl/cyrillic_utf8_to_latin_translit_top.sv]
// Top level of the Cyrillic to Latin transliterator for UTF-8 byte streams.
// Depends on cyrtl_pkg and instantiates cyrtl_xlat.
//
// The request channel (req_valid, req_stall, req_in_byte, req_flush) takes one
// text byte per word at a rising edge where req_valid is high and req_stall is
// low. A two-byte lead byte is held and yields nothing; the next word pairs
// with it. A Russian letter pair yields its 1 to 3 Latin bytes, any other pair
// both bytes unchanged, and every other byte passes through. A word with
// req_flush set emits a held lead byte alone, or nothing if none is held.
// The response channel (rsp_valid, rsp_stall, rsp_out_byte, rsp_out_last)
// delivers one byte per word; rsp_out_last marks the final byte caused by one
// request word.
// The group register takes the result bytes of a request word at the edge
// that accepts it; a word yielding no byte loads nothing into it. The group
// register hands one byte per cycle to the output register while that is
// free, and a new word is taken only once it is empty or hands over its last.
// A stall on the response side holds the output register; the group register
// then fills and req_stall rises until the backlog drains. Synchronous
// active-high reset empties both registers and drops any held lead byte.
`default_nettype none

module cyrillic_utf8_to_latin_translit_top (
   input  wire logic       clock,
   input  wire logic       reset,
   // Request channel.
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_flush,
   // Response channel.
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);

   // Held lead byte state.
   logic            pending_ff, pending_in;
   logic [7:0]      held_ff, held_in;

   // Group register: all result bytes of one request word, and the position
   // of the next one to hand over.
   logic            grp_vld_ff, grp_vld_in;
   logic [2:0][7:0] grp_byte_ff, grp_byte_in;
   logic [1:0]      grp_cnt_ff, grp_cnt_in;
   logic [1:0]      grp_pos_ff, grp_pos_in;

   // Output register.
   logic            out_vld_ff, out_vld_in;
   logic [7:0]      out_byte_ff, out_byte_in;
   logic            out_last_ff, out_last_in;

   cyrtl_pkg::cyrtl_xlat_type xlat;

   logic out_free;
   logic grp_move;
   logic grp_last;
   logic grp_done;
   logic accept;

   cyrtl_xlat u_xlat (
      .in_flush (req_flush),
      .in_byte  (req_in_byte),
      .pending  (pending_ff),
      .held     (held_ff),
      .xlat     (xlat)
   );

   // The output register can take a byte when it is empty or being taken.
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign grp_move  = grp_vld_ff && out_free;
   assign grp_last  = (grp_pos_ff == (grp_cnt_ff - 2'd1));
   assign grp_done  = grp_move && grp_last;
   // A new word may enter as soon as the group register is empty or hands
   // over its final byte in this cycle.
   assign req_stall = grp_vld_ff && !grp_done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pending_in = pending_ff;
      held_in    = held_ff;
      if (accept) begin
         pending_in = xlat.hold;
         held_in    = xlat.held;
      end
   end

   always_comb begin
      grp_vld_in  = grp_vld_ff;
      grp_byte_in = grp_byte_ff;
      grp_cnt_in  = grp_cnt_ff;
      grp_pos_in  = grp_pos_ff;
      if (accept && xlat.count != 2'd0) begin
         grp_vld_in  = 1'b1;
         grp_byte_in = xlat.bytes;
         grp_cnt_in  = xlat.count;
         grp_pos_in  = 2'd0;
      end else if (grp_done) begin
         grp_vld_in = 1'b0;
      end else if (grp_move) begin
         grp_pos_in = grp_pos_ff + 2'd1;
      end
   end

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (grp_move) begin
         out_vld_in  = 1'b1;
         out_byte_in = grp_byte_ff[grp_pos_ff];
         out_last_in = grp_last;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         held_ff    <= 8'h00;
         grp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         held_ff    <= held_in;
         grp_vld_ff <= grp_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      grp_byte_ff <= grp_byte_in;
      grp_cnt_ff  <= grp_cnt_in;
      grp_pos_ff  <= grp_pos_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;

`ifndef SYNTHESIS
   // A live group always has bytes left to hand over.
   a_grp_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      grp_vld_ff |-> (grp_cnt_ff != 2'd0 && grp_pos_ff < grp_cnt_ff))
      else $error("group position out of range");

   // A held byte is always a two-byte lead.
   a_held_is_lead: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (held_ff[7:5] == cyrtl_pkg::LEAD_TOP))
      else $error("held byte is not a lead byte");

   // A lead byte taken with nothing held is held on the next cycle.
   a_lead_held: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_flush && !pending_ff && req_in_byte[7:5] == cyrtl_pkg::LEAD_TOP)
      |=> (pending_ff && held_ff == $past(req_in_byte)))
      else $error("lead byte was not held");

   // Any word taken while a lead is held releases it.
   a_lead_released: assert property (@(posedge clock) disable iff (reset)
      (accept && pending_ff) |=> !pending_ff)
      else $error("held lead byte not released");
`endif

endmodule

`default_nettype wire
